>>> rtl/amc_pkg.sv
// Package for the MADT census block: widths, status codes, entry kinds and
// the queue word between front and back. No dependencies.
`timescale 1ns / 1ps
package amc_pkg;
    localparam int OffW = 21;
    localparam int TallyW = 18;
    localparam logic [OffW-1:0] MaxOffset = 21'h1FFFFF;
    localparam logic [TallyW-1:0] MaxTally = 18'h3FFFF;
    localparam logic [20:0] MaxLenReset = 21'h100000;
    localparam int QueueDepthDefault = 2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_SIG = 3'd1;
    localparam logic [2:0] ST_BAD_LEN = 3'd2;
    localparam logic [2:0] ST_BAD_SUM = 3'd3;
    localparam logic [2:0] ST_UNDER_44 = 3'd4;
    localparam logic [2:0] ST_SHORT = 3'd5;

    localparam logic [7:0] KIND_LAPIC = 8'd0;
    localparam logic [7:0] KIND_IOAPIC = 8'd1;
    localparam logic [7:0] KIND_OVERRIDE = 8'd5;
    localparam logic [7:0] KIND_X2APIC = 8'd9;

    localparam logic [OffW-1:0] OffLapic = 21'd36;
    localparam logic [OffW-1:0] OffEntries = 21'd44;

    // Classified beat passed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic [OffW-1:0] offset;
        logic last;
    } beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic walk_stopped;
        logic [63:0] apic_base_address;
        logic [TallyW-1:0] enabled_cpu_count;
        logic [TallyW-1:0] io_controller_count;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] r;
        begin
            unique case (idx)
                2'd0: r = 8'h41;
                2'd1: r = 8'h50;
                2'd2: r = 8'h49;
                default: r = 8'h43;
            endcase
            return r;
        end
    endfunction
endpackage

>>> rtl/amc_if.sv
// Valid/ready channel interfaces for the MADT census block.
// No dependencies.
`timescale 1ns / 1ps
interface amc_in_if;
    logic valid;
    logic ready;
    logic [7:0] table_byte;
    logic last_byte;
    modport source (output valid, table_byte, last_byte, input ready);
    modport sink (input valid, table_byte, last_byte, output ready);
endinterface

interface amc_out_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic walk_stopped;
    logic [63:0] apic_base_address;
    logic [17:0] enabled_cpu_count;
    logic [17:0] io_controller_count;
    modport source (output valid, status, walk_stopped, apic_base_address,
        enabled_cpu_count, io_controller_count, input ready);
    modport sink (input valid, status, walk_stopped, apic_base_address,
        enabled_cpu_count, io_controller_count, output ready);
endinterface

>>> rtl/amc_front.sv
// Front part: accepts table bytes and tags each with its offset.
// Depends on amc_pkg.
`timescale 1ns / 1ps
module amc_front
    import amc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] in_byte,
    input  logic in_last,
    output logic q_valid,
    input  logic q_ready,
    output beat_t q_beat
);
    logic [OffW-1:0] offset_reg, offset_next;

    assign in_ready = q_ready;
    assign q_valid = in_valid;
    assign q_beat = '{data: in_byte, offset: offset_reg, last: in_last};

    always_comb
    begin
        offset_next = offset_reg;
        if (in_valid && q_ready)
        begin
            if (in_last)
                offset_next = '0;
            else if (offset_reg != MaxOffset)
                offset_next = offset_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end
endmodule

>>> rtl/amc_queue.sv
// Short FIFO of classified beats between front and back.
// Depends on amc_pkg.
`timescale 1ns / 1ps
module amc_queue
    import amc_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  beat_t wr_beat,
    output logic rd_valid,
    input  logic rd_ready,
    output beat_t rd_beat
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    beat_t mem [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic push, pop;

    assign wr_ready = (cnt_reg != CW'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_beat = mem[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

>>> rtl/amc_back.sv
// Back part: header checks, checksum, entry walk and the result register.
// Depends on amc_pkg.
`timescale 1ns / 1ps
module amc_back
    import amc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic [20:0] max_len,
    input  logic b_valid,
    output logic b_ready,
    input  beat_t b_beat,
    output logic r_valid,
    input  logic r_ready,
    output result_t r_data
);
    logic [31:0] hlen_reg, hlen_next;
    logic [7:0] sum_reg, sum_next;
    logic sig_reg, sig_next;
    logic [OffW-1:0] estart_reg, estart_next;
    logic [7:0] kind_reg, kind_next, size_reg, size_next;
    logic halt_reg, halt_next;
    logic [63:0] addr_reg, addr_next, ovr_reg, ovr_next;
    logic [TallyW-1:0] cpu_reg, cpu_next, io_reg, io_next;
    logic rv_reg;
    result_t res_reg, res_next;

    logic take, in_len, walk;
    logic [7:0] b;
    logic [OffW-1:0] off, rel;
    logic [21:0] eend, nstart;
    logic [21:0] seen;
    logic [2:0] st;

    // Only a last beat writes the result register, so other beats keep
    // flowing while a result waits.
    assign b_ready = !rv_reg || r_ready || !(b_valid && b_beat.last);
    assign take = b_valid && b_ready;
    assign r_valid = rv_reg;
    assign r_data = res_reg;
    assign b = b_beat.data;
    assign off = b_beat.offset;

    always_comb
    begin
        hlen_next = hlen_reg; sum_next = sum_reg; sig_next = sig_reg;
        estart_next = estart_reg; kind_next = kind_reg; size_next = size_reg;
        halt_next = halt_reg; addr_next = addr_reg; ovr_next = ovr_reg;
        cpu_next = cpu_reg; io_next = io_reg; res_next = res_reg;
        rel = off - estart_reg;
        in_len = ({11'd0, off} < hlen_reg);
        walk = !halt_reg && (off >= estart_reg) && in_len;
        eend = {1'b0, estart_reg} + {14'd0, b};
        nstart = {1'b0, estart_reg} + {14'd0, size_reg};
        seen = {1'b0, off} + 22'd1;
        st = ST_OK;
        if (take)
        begin
            if (off < 21'd4 && b != sig_byte(off[1:0]))
                sig_next = 1'b0;
            if (off >= 21'd4 && off < 21'd8)
                hlen_next[off[1:0]*8 +: 8] = b;
            if (off < 21'd8 || in_len)
                sum_next = sum_reg + b;
            if (off >= OffLapic && off < OffLapic + 21'd4)
                addr_next[off[1:0]*8 +: 8] = b;
            if (walk)
            begin
                if (rel == '0)
                    kind_next = b;
                else if (rel == 21'd1)
                begin
                    size_next = b;
                    if (b < 8'd2 || {10'd0, eend} > hlen_reg)
                        halt_next = 1'b1;
                    else if (kind_reg == KIND_IOAPIC && b >= 8'd12 && io_reg != MaxTally)
                        io_next = io_reg + 1'b1;
                end
                else
                begin
                    if (kind_reg == KIND_LAPIC && rel == 21'd4 && size_reg >= 8'd8
                        && b[0] && cpu_reg != MaxTally)
                        cpu_next = cpu_reg + 1'b1;
                    if (kind_reg == KIND_X2APIC && rel == 21'd8 && size_reg >= 8'd16
                        && b[0] && cpu_reg != MaxTally)
                        cpu_next = cpu_reg + 1'b1;
                    if (kind_reg == KIND_OVERRIDE && size_reg >= 8'd12
                        && rel >= 21'd4 && rel <= 21'd11)
                    begin
                        // Entry bytes 4 to 11 land in address bytes 0 to 7.
                        ovr_next[{~rel[2], rel[1:0]}*8 +: 8] = b;
                        if (rel == 21'd11)
                            addr_next = {b, ovr_reg[55:0]};
                    end
                end
                // Entry end: rel==1 case uses the new size byte.
                if (rel == 21'd1 && !(b < 8'd2 || {10'd0, eend} > hlen_reg))
                begin
                    if (b == 8'd2)
                        estart_next = eend[21] ? MaxOffset : eend[20:0];
                end
                else if (rel >= 21'd2 && rel == {13'd0, size_reg} - 21'd1)
                    estart_next = nstart[21] ? MaxOffset : nstart[20:0];
            end
            if (b_beat.last)
            begin
                if (!sig_next) st = ST_BAD_SIG;
                else if (seen < 22'd8) st = ST_SHORT;
                else if (hlen_next < 32'd36 || hlen_next > {11'd0, max_len}) st = ST_BAD_LEN;
                else if ({10'd0, seen} < hlen_next) st = ST_SHORT;
                else if (sum_next != 8'd0) st = ST_BAD_SUM;
                else if (hlen_next < 32'd44) st = ST_UNDER_44;
                res_next.status = st;
                res_next.walk_stopped = (st == ST_OK) && halt_next;
                res_next.apic_base_address = (st == ST_OK) ? addr_next : '0;
                res_next.enabled_cpu_count = (st == ST_OK) ? cpu_next : '0;
                res_next.io_controller_count = (st == ST_OK) ? io_next : '0;
                hlen_next = '0; sum_next = '0; sig_next = 1'b1;
                estart_next = OffEntries; kind_next = '0; size_next = '0;
                halt_next = 1'b0; addr_next = '0; ovr_next = '0;
                cpu_next = '0; io_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlen_reg <= '0; sum_reg <= '0; sig_reg <= 1'b1;
            estart_reg <= OffEntries; kind_reg <= '0; size_reg <= '0;
            halt_reg <= 1'b0; addr_reg <= '0; ovr_reg <= '0;
            cpu_reg <= '0; io_reg <= '0;
            rv_reg <= 1'b0;
        end
        else
        begin
            hlen_reg <= hlen_next; sum_reg <= sum_next; sig_reg <= sig_next;
            estart_reg <= estart_next; kind_reg <= kind_next; size_reg <= size_next;
            halt_reg <= halt_next; addr_reg <= addr_next; ovr_reg <= ovr_next;
            cpu_reg <= cpu_next; io_reg <= io_next;
            if (take && b_beat.last)
                rv_reg <= 1'b1;
            else if (r_ready)
                rv_reg <= 1'b0;
        end
    end
endmodule

>>> rtl/acpi_madt_census.sv
// Top level of the MADT census block: front, beat queue and back.
// Depends on amc_pkg, amc_if, amc_front, amc_queue and amc_back.
//
//   channel | direction | payload
//   in      | sink      | table_byte, last_byte
//   out     | source    | status, walk_stopped, apic_base_address, counts
//   cfg     | write     | max_table_length (21 bits)
//
// One table byte is taken per cycle while the queue has room; the back
// retires one beat per cycle unless a last beat waits on a held result,
// so the sustained rate is one beat a cycle, set by the back's update of
// the walk state. A result is registered as the last beat leaves the queue
// and waits in the result register; the back keeps taking beats while it
// waits unless a second result is due. Reset restores all control state and sets max_table_length to 1048576.
`timescale 1ns / 1ps
module acpi_madt_census
    import amc_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    amc_in_if.sink in_ch,
    amc_out_if.source out_ch,
    input  logic cfg_we,
    input  logic [20:0] cfg_wdata
);
    logic [20:0] max_len_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    beat_t fq_beat, qb_beat;
    result_t res;

    // The table-length limit; the user must write it only while the block is idle, which is not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MaxLenReset;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    amc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_byte(in_ch.table_byte), .in_last(in_ch.last_byte),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_beat(fq_beat)
    );

    amc_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_beat(fq_beat),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_beat(qb_beat)
    );

    amc_back u_back (
        .clk(clk), .rst_n(rst_n), .max_len(max_len_reg),
        .b_valid(qb_valid), .b_ready(qb_ready), .b_beat(qb_beat),
        .r_valid(out_ch.valid), .r_ready(out_ch.ready), .r_data(res)
    );

    assign out_ch.status = res.status;
    assign out_ch.walk_stopped = res.walk_stopped;
    assign out_ch.apic_base_address = res.apic_base_address;
    assign out_ch.enabled_cpu_count = res.enabled_cpu_count;
    assign out_ch.io_controller_count = res.io_controller_count;
endmodule
